// File: design/irfoc_pkg.sv
`default_nettype none

package irfoc_pkg;

  // Largest capture the block will pack, in bytes.
  localparam int unsigned MAX_BYTES = 512;

  // Capture size register is 10 bits wide, so the clamp never exceeds 1023.
  localparam int unsigned MaxClamp = (MAX_BYTES > 1023) ? 1023 : MAX_BYTES;
  localparam logic [9:0] MAX_N = 10'(MaxClamp);

  // Register reset values.
  localparam logic [9:0] DEBOUNCE_RESET = 10'd50;
  localparam logic [9:0] CAPTURE_RESET  = 10'd300;

  // Register indices on the configuration port.
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_CAPTURE  = 2'd1;

  // One sample word.
  typedef struct packed {
    logic line_level;
    logic arm;
  } in_t;

  // One packed byte word.
  typedef struct packed {
    logic [7:0] byte_value;
    logic [8:0] byte_index;
    logic       last;
    logic [9:0] end_position;
    logic       end_found;
  } out_t;

endpackage

`default_nettype wire

// File: design/ir_frame_oversampling_capture.sv
// Channel  | Handshake             | Word
// ---------+-----------------------+-----------------------------------------
// in       | in_valid / in_ready   | in_data    : in_t  (line_level, arm)
// out      | out_valid / out_ready | out_data   : out_t (byte and end report)
// cfg      | cfg_we (no wait)      | cfg_index, cfg_data (10 bits)
//
// One sample word is taken every cycle unless the output register is stalled;
// its effect on the capture state and any packed byte it completes are
// settled in that same cycle and the byte is held in a single output register,
// valid in the cycle after its sample. A stalled output register holds back
// the input only while it is full and not being taken. Reset (synchronous)
// leaves the block disarmed with both registers at their default values.

`default_nettype none

module ir_frame_oversampling_capture
  import irfoc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_t        in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_t            out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [9:0] cfg_data
);

  localparam logic [2:0] PH_DISARMED    = 3'd0;
  localparam logic [2:0] PH_WAIT_EDGE   = 3'd1;
  localparam logic [2:0] PH_DEBOUNCE    = 3'd2;
  localparam logic [2:0] PH_LEADER_LOW  = 3'd3;
  localparam logic [2:0] PH_LEADER_HIGH = 3'd4;
  localparam logic [2:0] PH_CAPTURE     = 3'd5;
  localparam logic [2:0] PH_DONE        = 3'd6;

  logic [9:0] debounce_ticks;
  logic [9:0] capture_bytes;

  logic [2:0] phase, phase_next;
  logic       previous_level, previous_level_next;
  logic [9:0] tick_counter, tick_counter_next;
  logic [2:0] bit_position, bit_position_next;
  logic [7:0] byte_accumulator, byte_accumulator_next;
  logic [9:0] byte_counter, byte_counter_next;
  logic [3:0] ones_byte_run, ones_byte_run_next;
  logic [9:0] end_index, end_index_next;
  logic       end_seen, end_seen_next;

  logic       res_valid;
  out_t       res;
  logic       in_accept;

  logic [9:0] size_raw;
  logic [9:0] size_eff;
  logic [7:0] acc_or;
  logic [9:0] count_inc;
  logic       is_last;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Effective capture size: zero counts as one, then clamp to the maximum.
  assign size_raw = (capture_bytes == 10'd0) ? 10'd1 : capture_bytes;
  assign size_eff = (size_raw > MAX_N) ? MAX_N : size_raw;

  assign acc_or    = byte_accumulator | (8'(in_data.line_level) << bit_position);
  assign count_inc = byte_counter + 10'd1;
  assign is_last   = (count_inc >= size_eff);

  // Next state and the byte word for one sample.
  always_comb begin
    phase_next            = phase;
    previous_level_next   = in_data.line_level;
    tick_counter_next     = tick_counter;
    bit_position_next     = bit_position;
    byte_accumulator_next = byte_accumulator;
    byte_counter_next     = byte_counter;
    ones_byte_run_next    = ones_byte_run;
    end_index_next        = end_index;
    end_seen_next         = end_seen;
    res_valid             = 1'b0;
    res                   = '0;

    if (in_data.arm) begin
      // Arm clears progress and leaves the edge tracker alone.
      previous_level_next   = previous_level;
      tick_counter_next     = '0;
      bit_position_next     = '0;
      byte_accumulator_next = '0;
      byte_counter_next     = '0;
      ones_byte_run_next    = '0;
      end_index_next        = '0;
      end_seen_next         = 1'b0;
      phase_next            = PH_WAIT_EDGE;
    end else begin
      unique case (phase)
        PH_WAIT_EDGE: begin
          if (previous_level && !in_data.line_level) begin
            tick_counter_next = debounce_ticks;
            phase_next        = PH_DEBOUNCE;
          end
        end
        PH_DEBOUNCE: begin
          if (tick_counter != 10'd0) begin
            tick_counter_next = tick_counter - 10'd1;
          end else begin
            phase_next = in_data.line_level ? PH_WAIT_EDGE : PH_LEADER_LOW;
          end
        end
        PH_LEADER_LOW: begin
          if (in_data.line_level) begin
            phase_next = PH_LEADER_HIGH;
          end
        end
        PH_LEADER_HIGH: begin
          if (!in_data.line_level) begin
            bit_position_next     = '0;
            byte_accumulator_next = '0;
            phase_next            = PH_CAPTURE;
          end
        end
        PH_CAPTURE: begin
          bit_position_next     = bit_position + 3'd1;
          byte_accumulator_next = acc_or;
          if (bit_position == 3'd7) begin
            // A byte is complete: track the run of all-ones bytes.
            if (acc_or == 8'hff) begin
              if (ones_byte_run < 4'd8) begin
                ones_byte_run_next = ones_byte_run + 4'd1;
              end
              if (ones_byte_run_next >= 4'd8 && !end_seen) begin
                end_seen_next  = 1'b1;
                end_index_next = count_inc;
              end
            end else begin
              ones_byte_run_next = '0;
            end
            byte_accumulator_next = '0;
            byte_counter_next     = count_inc;
            res_valid             = 1'b1;
            res.byte_value        = acc_or;
            res.byte_index        = byte_counter[8:0];
            res.last              = is_last;
            if (is_last) begin
              res.end_position = end_seen_next ? end_index_next : size_eff + 10'd2;
              res.end_found    = end_seen_next;
              phase_next       = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      capture_bytes  <= CAPTURE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_DEBOUNCE) begin
        debounce_ticks <= cfg_data;
      end else if (cfg_index == REG_CAPTURE) begin
        capture_bytes <= cfg_data;
      end
    end
  end

  // Capture state, advanced on each accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_DISARMED;
      previous_level   <= 1'b1;
      tick_counter     <= '0;
      bit_position     <= '0;
      byte_accumulator <= '0;
      byte_counter     <= '0;
      ones_byte_run    <= '0;
      end_index        <= '0;
      end_seen         <= 1'b0;
    end else if (in_accept) begin
      phase            <= phase_next;
      previous_level   <= previous_level_next;
      tick_counter     <= tick_counter_next;
      bit_position     <= bit_position_next;
      byte_accumulator <= byte_accumulator_next;
      byte_counter     <= byte_counter_next;
      ones_byte_run    <= ones_byte_run_next;
      end_index        <= end_index_next;
      end_seen         <= end_seen_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// File: verif/ir_frame_oversampling_capture_tb.sv
`timescale 1ns / 100ps

module ir_frame_oversampling_capture_tb;
  import irfoc_pkg::*;

  // Spare register indices that the block must ignore.
  localparam logic [1:0] REG_SPARE     = 2'd2;
  localparam logic [1:0] REG_SPARE_TOP = 2'd3;

  // Sample words used by the directed table.
  localparam in_t LO     = '{line_level: 1'b0, arm: 1'b0};
  localparam in_t HI     = '{line_level: 1'b1, arm: 1'b0};
  localparam in_t ARM_LO = '{line_level: 1'b0, arm: 1'b1};
  localparam in_t ARM_HI = '{line_level: 1'b1, arm: 1'b1};

  localparam out_t NO_WORD    = '0;
  localparam out_t FIRST_BYTE = '{byte_value: 8'h55, byte_index: 9'd0, last: 1'b1,
                                  end_position: 10'd3, end_found: 1'b0};

  typedef enum logic [2:0] {
    ST_DISARMED, ST_WAIT_EDGE, ST_DEBOUNCE, ST_LEADER_LOW, ST_LEADER_HIGH,
    ST_CAPTURE, ST_DONE
  } cap_state_t;

  typedef struct packed {
    in_t  word;
    logic has_exp;
    out_t exp;
  } dir_row_t;

  // Directed frame with a debounce of zero and a capture size of zero (taken
  // as one): edge tracking across an arm, a rejected glitch, both leaders and
  // one byte packed least significant bit first, then ignored and re-armed.
  dir_row_t dir_rows [24] = '{
    '{LO, 1'b0, NO_WORD}, '{ARM_HI, 1'b0, NO_WORD}, '{LO, 1'b0, NO_WORD},
    '{HI, 1'b0, NO_WORD}, '{LO, 1'b0, NO_WORD}, '{HI, 1'b0, NO_WORD},
    '{LO, 1'b0, NO_WORD}, '{LO, 1'b0, NO_WORD}, '{LO, 1'b0, NO_WORD},
    '{HI, 1'b0, NO_WORD}, '{HI, 1'b0, NO_WORD}, '{LO, 1'b0, NO_WORD},
    '{HI, 1'b0, NO_WORD}, '{LO, 1'b0, NO_WORD}, '{HI, 1'b0, NO_WORD},
    '{LO, 1'b0, NO_WORD}, '{HI, 1'b0, NO_WORD}, '{LO, 1'b0, NO_WORD},
    '{HI, 1'b0, NO_WORD}, '{LO, 1'b1, FIRST_BYTE}, '{HI, 1'b0, NO_WORD},
    '{LO, 1'b0, NO_WORD}, '{ARM_LO, 1'b0, NO_WORD}, '{ARM_HI, 1'b0, NO_WORD}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_DEBOUNCE;
  logic [9:0] cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned mismatches = 0;

  // Bytes still to come out of the block, oldest first.
  out_t pending_bytes [$];

  // Shadow of the capture state and the two registers.
  cap_state_t st;
  logic       prev_level;
  logic [9:0] tick_left;
  logic [2:0] bit_pos;
  logic [7:0] acc;
  logic [9:0] bytes_done;
  logic [3:0] ff_run;
  logic [9:0] run_end;
  logic       run_seen;
  logic [9:0] reg_debounce;
  logic [9:0] reg_capture;

  ir_frame_oversampling_capture dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Capture size as the block uses it: zero counts as one, clamped at the top.
  function automatic logic [9:0] frame_size();
    if (reg_capture == 10'd0) return 10'd1;
    if (reg_capture > 10'(MAX_BYTES)) return 10'(MAX_BYTES);
    return reg_capture;
  endfunction

  function automatic void clear_frame();
    tick_left  = '0;
    bit_pos    = '0;
    acc        = '0;
    bytes_done = '0;
    ff_run     = '0;
    run_end    = '0;
    run_seen   = 1'b0;
  endfunction

  // Advances the shadow state by one sample; returns 1 when a byte completes.
  function automatic bit pack_sample(input in_t w, output out_t r);
    logic       was;
    logic [9:0] n;
    r   = '0;
    was = prev_level;
    if (w.arm) begin
      clear_frame();
      st = ST_WAIT_EDGE;
      return 1'b0;
    end
    prev_level = w.line_level;
    case (st)
      ST_WAIT_EDGE: begin
        if (was && !w.line_level) begin
          tick_left = reg_debounce;
          st = ST_DEBOUNCE;
        end
      end
      ST_DEBOUNCE: begin
        if (tick_left != 10'd0) tick_left = tick_left - 10'd1;
        else st = w.line_level ? ST_WAIT_EDGE : ST_LEADER_LOW;
      end
      ST_LEADER_LOW: begin
        if (w.line_level) st = ST_LEADER_HIGH;
      end
      ST_LEADER_HIGH: begin
        if (!w.line_level) begin
          bit_pos = '0;
          acc = '0;
          st = ST_CAPTURE;
        end
      end
      ST_CAPTURE: begin
        n = frame_size();
        if (w.line_level) acc[bit_pos] = 1'b1;
        bit_pos = bit_pos + 3'd1;
        if (bit_pos == 3'd0) begin
          // Track the first run of eight all-high bytes.
          if (acc == 8'hff) begin
            if (ff_run < 4'd8) ff_run = ff_run + 4'd1;
            if (ff_run >= 4'd8 && !run_seen) begin
              run_seen = 1'b1;
              run_end = bytes_done + 10'd1;
            end
          end else begin
            ff_run = '0;
          end
          r.byte_value = acc;
          r.byte_index = bytes_done[8:0];
          acc = '0;
          bytes_done = bytes_done + 10'd1;
          r.last = (bytes_done >= n);
          if (r.last) begin
            r.end_position = run_seen ? run_end : n + 10'd2;
            r.end_found = run_seen;
            st = ST_DONE;
          end
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input out_t want, input out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected value %02h index %0d last %0d end %0d found %0d",
               $realtime, what, want.byte_value, want.byte_index, want.last,
               want.end_position, want.end_found);
      $display("    got value %02h index %0d last %0d end %0d found %0d",
               got.byte_value, got.byte_index, got.last, got.end_position,
               got.end_found);
    end
  endtask

  // Receiver: random stalls at the rate of the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare every byte word taken from the block with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin : check_byte
      out_t want;
      if (pending_bytes.size() == 0) begin
        report_mismatch("byte word with none expected", NO_WORD, out_data);
      end else begin
        want = pending_bytes.pop_front();
        if (out_data.byte_value !== want.byte_value ||
            out_data.byte_index !== want.byte_index ||
            out_data.last !== want.last ||
            out_data.end_position !== want.end_position ||
            out_data.end_found !== want.end_found)
          report_mismatch("byte word mismatch", want, out_data);
      end
    end
  end

  // Offer one sample word, hold it until taken, then predict its effect.
  task automatic send_word(input in_t w, input bit typed = 1'b0, input out_t typed_word = '0);
    out_t r;
    bit   made;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    made = pack_sample(w, r);
    if (typed) pending_bytes.push_back(typed_word);
    else if (made) pending_bytes.push_back(r);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_level(input logic lvl);
    send_word('{line_level: lvl, arm: 1'b0});
  endtask

  // Stop sending and wait until every predicted byte has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_bytes.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Register writes happen only with the block drained.
  task automatic set_regs(input logic [9:0] deb, input logic [9:0] cap, input bit poke_spare);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= deb;
    reg_debounce = deb;
    @(negedge clk);
    cfg_index <= REG_CAPTURE;
    cfg_data  <= cap;
    reg_capture = cap;
    @(negedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE;
      cfg_data  <= 10'($urandom_range(1023));
      @(negedge clk);
      cfg_index <= REG_SPARE_TOP;
      cfg_data  <= 10'h3ff;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Arm, idle high, optional glitch, falling edge, debounce and both leaders.
  task automatic start_frame();
    send_word('{line_level: 1'($urandom_range(1)), arm: 1'b1});
    repeat ($urandom_range(1, 3)) send_level(1'b1);
    if ($urandom_range(4) == 0) begin
      send_level(1'b0);
      repeat (int'(reg_debounce)) send_level(1'($urandom_range(1)));
      send_level(1'b1);
      send_level(1'b1);
    end
    send_level(1'b0);
    repeat (int'(reg_debounce)) send_level(1'($urandom_range(1)));
    send_level(1'b0);
    repeat ($urandom_range(1, 4)) send_level(1'b0);
    repeat ($urandom_range(1, 4)) send_level(1'b1);
    send_level(1'b0);
  endtask

  // Packed bytes: all-high with the given percentage, else zero or random.
  task automatic send_bytes(input int count, input int unsigned ff_pct);
    logic [7:0] v;
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < ff_pct) v = 8'hff;
      else if (pick < ff_pct + 10) v = 8'h00;
      else v = 8'($urandom_range(255));
      for (int b = 0; b < 8; b++) send_level(v[b]);
    end
  endtask

  task automatic send_noise(input int count);
    repeat (count)
      send_word('{line_level: 1'($urandom_range(1)), arm: ($urandom_range(9) == 0)});
  endtask

  task automatic random_frame();
    logic [9:0] deb;
    logic [9:0] cap;
    int unsigned ff_pct;
    int nb;
    if ($urandom_range(3) == 0) begin
      deb = ($urandom_range(11) == 0) ? 10'($urandom_range(5, 40)) : 10'($urandom_range(4));
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: cap = 10'($urandom_range(1, 6));
        6, 7, 8:          cap = 10'($urandom_range(8, 14));
        default:          cap = 10'd0;
      endcase
      set_regs(deb, cap, $urandom_range(3) == 0);
    end
    case ($urandom_range(2))
      0:       ff_pct = 0;
      1:       ff_pct = 40;
      default: ff_pct = 90;
    endcase
    start_frame();
    nb = int'(frame_size());
    if ($urandom_range(9) == 0) begin
      // Cut the frame short; the next arm drops it.
      send_bytes($urandom_range(nb - 1), ff_pct);
      send_noise($urandom_range(7));
    end else begin
      send_bytes(nb, ff_pct);
      repeat ($urandom_range(2)) send_level(1'($urandom_range(1)));
    end
    if ($urandom_range(4) == 0) send_noise($urandom_range(1, 6));
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    reg_debounce = DEBOUNCE_RESET;
    reg_capture  = CAPTURE_RESET;
    st = ST_DISARMED;
    prev_level = 1'b1;
    clear_frame();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table.
    set_regs(10'd0, 10'd0, 1'b1);
    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].has_exp, dir_rows[i].exp);
    wait_drained();

    // Random frames under four idling patterns.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      case (p)
        0: begin
          // Long debounce, single byte frame.
          set_regs(10'd100, 10'd1, 1'b0);
          start_frame();
          send_bytes(1, 40);
          set_regs(10'd2, 10'd5, 1'b1);
        end
        1: begin
          // Oversized capture register, then shrunk part way through the frame.
          set_regs(10'd1, 10'd1023, 1'b0);
          start_frame();
          send_bytes(4, 0);
          set_regs(10'd1, 10'd6, 1'b0);
          send_bytes(2, 0);
        end
        2: begin
          // All-high frame: the run ends at the eighth byte.
          set_regs(10'd3, 10'd12, 1'b0);
          start_frame();
          send_bytes(12, 100);
        end
        default: begin
          // Capture size shrunk part way through a frame.
          set_regs(10'd0, 10'd6, 1'b0);
          start_frame();
          send_bytes(3, 90);
          set_regs(10'd0, 10'd2, 1'b0);
          send_bytes(3, 90);
        end
      endcase
      phase_start = words_sent;
      while (words_sent - phase_start < 240) random_frame();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
design/irfoc_pkg.sv
design/ir_frame_oversampling_capture.sv
verif/ir_frame_oversampling_capture_tb.sv
